[sv/ccl_pkg.sv]
package ccl_pkg;

    // character codes that the scanner matches
    localparam logic [7:0] CH_NL    = 8'd10;
    localparam logic [7:0] CH_SP    = 8'd32;
    localparam logic [7:0] CH_QUOTE = 8'd34;
    localparam logic [7:0] CH_STAR  = 8'd42;
    localparam logic [7:0] CH_SLASH = 8'd47;

    // input action codes
    localparam logic ACT_BYTE = 1'b0;
    localparam logic ACT_EOF  = 1'b1;

    // one-character lookahead hold
    typedef enum logic [1:0] {
        HOLD_NONE  = 2'd0,
        HOLD_SLASH = 2'd1,
        HOLD_STAR  = 2'd2
    } hold_t;

    // scanner flags carried from byte to byte
    typedef struct packed {
        logic  in_block_comment;
        logic  in_quote;
        logic  line_has_code;
        logic  skip_rest_of_line;
        hold_t held_char;
    } scan_state_t;

    localparam scan_state_t SCAN_RESET = '{
        in_block_comment:  1'b0,
        in_quote:          1'b0,
        line_has_code:     1'b0,
        skip_rest_of_line: 1'b0,
        held_char:         HOLD_NONE
    };

endpackage

[sv/ccl_step.sv]
module ccl_step #(
    parameter int COUNT_BITS = 32
) (
    input  ccl_pkg::scan_state_t   state_cur,
    input  logic [COUNT_BITS-1:0]  count_cur,
    input  logic                   action,
    input  logic [7:0]             char_code,
    output ccl_pkg::scan_state_t   state_next,
    output logic [COUNT_BITS-1:0]  count_next,
    output logic                   line_done
);
    import ccl_pkg::*;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    // per-byte next-state logic
    always_comb
    begin
        scan_state_t s;
        logic        used;
        logic        has_code;
        s        = state_cur;
        used     = 1'b0;
        has_code = 1'b0;
        count_next = count_cur;
        line_done  = 1'b0;
        if (action == ACT_EOF || char_code == CH_NL)
        begin
            // line close: a held slash outside a block counts as code
            line_done = 1'b1;
            has_code  = s.line_has_code ||
                        (s.held_char == HOLD_SLASH && !s.in_block_comment);
            if (has_code && !s.in_block_comment && count_cur != COUNT_MAX)
            begin
                count_next = count_cur + 1'b1;
            end
            s.in_quote          = 1'b0;
            s.line_has_code     = 1'b0;
            s.skip_rest_of_line = 1'b0;
            s.held_char         = HOLD_NONE;
        end
        else if (char_code != CH_SP && !s.skip_rest_of_line)
        begin
            // resolve a held character against this byte
            if (s.held_char == HOLD_SLASH)
            begin
                if (!s.in_quote && !s.in_block_comment && char_code == CH_SLASH)
                begin
                    s.skip_rest_of_line = 1'b1;
                    used = 1'b1;
                end
                else if (!s.in_quote && char_code == CH_STAR)
                begin
                    s.in_block_comment = 1'b1;
                    used = 1'b1;
                end
                else if (!s.in_block_comment)
                begin
                    s.line_has_code = 1'b1;
                end
                s.held_char = HOLD_NONE;
            end
            else if (s.held_char == HOLD_STAR)
            begin
                if (char_code == CH_SLASH)
                begin
                    s.in_block_comment = 1'b0;
                    used = 1'b1;
                end
                s.held_char = HOLD_NONE;
            end
            // take the byte on its own
            if (!used)
            begin
                if (!s.in_quote && char_code == CH_SLASH)
                begin
                    s.held_char = HOLD_SLASH;
                end
                else if (!s.in_quote && s.in_block_comment && char_code == CH_STAR)
                begin
                    s.held_char = HOLD_STAR;
                end
                else if (!s.in_block_comment)
                begin
                    s.line_has_code = 1'b1;
                    if (char_code == CH_QUOTE)
                    begin
                        s.in_quote = !s.in_quote;
                    end
                end
            end
        end
        state_next = s;
    end

endmodule

[sv/code_line_counter.sv]
// channel  | direction | handshake           | payload
// ---------+-----------+---------------------+------------------------------
// input    | in        | in_valid / in_stall | action, char_code
// output   | out       | out_valid/out_stall | line_count, line_done
//
// one transaction per cycle sustained while out_stall stays low; the input register loads at the
// accepting edge and the result register when the item advances.
// the scan flags and line counter update when an item moves from the input
// register into the result register, so throughput is set by that one step.
// reset clears the flags, the hold, the counter and both valid bits.
// a stall on the output holds the result register; the input register then
// fills and in_stall rises, with no transaction lost or repeated.
module code_line_counter #(
    parameter int COUNT_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        action,
    input  logic [7:0]  char_code,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] line_count,
    output logic        line_done
);
    import ccl_pkg::*;

    logic                  in_valid_reg;
    logic                  action_reg;
    logic [7:0]            char_reg;
    scan_state_t           state_reg;
    scan_state_t           state_next;
    logic [COUNT_BITS-1:0] count_reg;
    logic [COUNT_BITS-1:0] count_next;
    logic                  done_next;
    logic                  out_valid_reg;
    logic [31:0]           line_count_reg;
    logic                  line_done_reg;
    logic                  advance;
    logic                  in_take;

    // item moves on when the result register is free or being emptied
    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            action_reg <= action;
            char_reg   <= char_code;
        end
    end

    // per-byte scan logic
    ccl_step #(
        .COUNT_BITS (COUNT_BITS)
    ) u_step (
        .state_cur  (state_reg),
        .count_cur  (count_reg),
        .action     (action_reg),
        .char_code  (char_reg),
        .state_next (state_next),
        .count_next (count_next),
        .line_done  (done_next)
    );

    // scan state and counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SCAN_RESET;
            count_reg <= '0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            line_count_reg <= 32'(count_next);
            line_done_reg  <= done_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign line_count = line_count_reg;
    assign line_done  = line_done_reg;

endmodule

[bench/tb.sv]
module tb;

    import ccl_pkg::*;

    // narrow counter so that saturation is reached within the run
    localparam int          COUNT_W   = 8;
    localparam logic [63:0] COUNT_MAX = (64'd1 << COUNT_W) - 64'd1;
    localparam int          RANDOM_ITEMS = 1800;

    typedef struct {
        logic       act;
        logic [7:0] code;
        bit         drain;
    } text_item_t;

    typedef struct {
        logic [31:0] count;
        logic        done;
    } line_result_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_stall;
    logic        action    = ACT_BYTE;
    logic [7:0]  char_code = 8'd0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [31:0] line_count;
    logic        line_done;

    code_line_counter #(
        .COUNT_BITS (COUNT_W)
    ) i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .action     (action),
        .char_code  (char_code),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .line_count (line_count),
        .line_done  (line_done)
    );

    always #4 clk = ~clk;

    text_item_t   text_queue[$];
    line_result_t line_results[$];
    text_item_t   next_text;
    line_result_t got_result;
    line_result_t want_result;
    bit           drain_next = 1'b0;

    int n_fail   = 0;
    int n_in     = 0;
    int n_out    = 0;
    int n_closed = 0;
    int n_sat    = 0;

    // scanner state mirrored in the testbench
    logic        blk_open;
    logic        quote_open;
    logic        line_code;
    logic        rest_skipped;
    hold_t       pend_hold;
    logic [63:0] code_total;

    // a held byte that formed no marker counts on its own
    function automatic void drop_hold();
        if (pend_hold == HOLD_SLASH && !blk_open)
            line_code = 1'b1;
        pend_hold = HOLD_NONE;
    endfunction

    function automatic void scan_fresh(input logic [7:0] c);
        if (!quote_open && c == CH_SLASH)
            pend_hold = HOLD_SLASH;
        else if (!quote_open && blk_open && c == CH_STAR)
            pend_hold = HOLD_STAR;
        else if (!blk_open)
        begin
            line_code = 1'b1;
            if (c == CH_QUOTE)
                quote_open = !quote_open;
        end
    endfunction

    // resolve the hold against the next byte, then take the byte itself
    function automatic void scan_char(input logic [7:0] c);
        if (pend_hold == HOLD_SLASH && !quote_open && !blk_open && c == CH_SLASH)
        begin
            pend_hold    = HOLD_NONE;
            rest_skipped = 1'b1;
        end
        else if (pend_hold == HOLD_SLASH && !quote_open && c == CH_STAR)
        begin
            pend_hold = HOLD_NONE;
            blk_open  = 1'b1;
        end
        else if (pend_hold == HOLD_STAR && c == CH_SLASH)
        begin
            pend_hold = HOLD_NONE;
            blk_open  = 1'b0;
        end
        else
        begin
            if (pend_hold != HOLD_NONE)
                drop_hold();
            scan_fresh(c);
        end
    endfunction

    function automatic void end_line();
        drop_hold();
        if (line_code && !blk_open)
        begin
            if (code_total < COUNT_MAX)
                code_total = code_total + 64'd1;
            else
                n_sat++;
        end
        quote_open   = 1'b0;
        line_code    = 1'b0;
        rest_skipped = 1'b0;
        pend_hold    = HOLD_NONE;
    endfunction

    function automatic line_result_t count_lines(input logic act, input logic [7:0] c);
        line_result_t r;
        r.done = 1'b0;
        if (act == ACT_EOF || c == CH_NL)
        begin
            end_line();
            r.done = 1'b1;
            n_closed++;
        end
        else if (c != CH_SP && !rest_skipped)
            scan_char(c);
        r.count = code_total[31:0];
        return r;
    endfunction

    task automatic add_item(input logic act, input logic [7:0] c);
        text_item_t t;
        t.act      = act;
        t.code     = c;
        t.drain    = drain_next;
        drain_next = 1'b0;
        text_queue.push_back(t);
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            add_item(ACT_BYTE, s[i]);
    endtask

    // driver: bursts of transactions separated by random gaps
    int burst_left = 1;
    int gap_left   = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            action     <= ACT_BYTE;
            char_code  <= 8'd0;
            blk_open     = 1'b0;
            quote_open   = 1'b0;
            line_code    = 1'b0;
            rest_skipped = 1'b0;
            pend_hold    = HOLD_NONE;
            code_total   = 64'd0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                line_results.push_back(count_lines(action, char_code));
                n_in++;
            end
            if (!in_valid || !in_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (text_queue.size() > 0 &&
                         !(text_queue[0].drain && line_results.size() > 0))
                begin
                    next_text = text_queue.pop_front();
                    in_valid  <= 1'b1;
                    action    <= next_text.act;
                    char_code <= next_text.code;
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        gap_left   = $urandom_range(1, 6);
                        burst_left = ($urandom_range(0, 9) == 0) ?
                                     $urandom_range(100, 300) : $urandom_range(1, 20);
                    end
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // receiver stall pattern: switches at random among no, sparse, dense and alternating stalls
    int stall_mode = 0;
    int stall_left = 50;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            stall_left--;
            if (stall_left <= 0)
            begin
                stall_left = $urandom_range(20, 200);
                stall_mode = $urandom_range(0, 3);
            end
            case (stall_mode)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 3) == 0);
                2: out_stall <= ($urandom_range(0, 3) != 0);
                default: out_stall <= !out_stall;
            endcase
        end
    end

    // monitor: compare each result transaction with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            got_result.count = line_count;
            got_result.done  = line_done;
            n_out++;
            if (line_results.size() == 0)
            begin
                $error("result with nothing pending: line_count %0d line_done %0b",
                       line_count, line_done);
                n_fail++;
            end
            else
            begin
                want_result = line_results.pop_front();
                if (got_result.count !== want_result.count)
                begin
                    $error("line_count: expected %0d, actual %0d",
                           want_result.count, got_result.count);
                    n_fail++;
                end
                if (got_result.done !== want_result.done)
                begin
                    $error("line_done: expected %0b, actual %0b",
                           want_result.done, got_result.done);
                    n_fail++;
                end
            end
        end
    end

    // stimulus and end of run
    int n_random;

    initial
    begin
        // directed: line comment across a space, block over lines,
        // slash star inside a block, quotes hiding markers, end of input
        add_text("a\n");
        add_text("/ /x\n");
        add_text("/*\nq\n");
        add_text("/*/\n");
        add_text("*/\"//\"");
        add_item(ACT_EOF, 8'hFF);
        add_item(ACT_BYTE, CH_SLASH);
        add_item(ACT_EOF, CH_NL);

        // random lines built from marker fragments mixed with letters and other bytes
        drain_next = 1'b1;
        n_random   = 0;
        while (n_random < RANDOM_ITEMS)
        begin
            repeat ($urandom_range(0, 5))
            begin
                case ($urandom_range(0, 15))
                    0: add_text("//");
                    1: add_text("/ /");
                    2: add_text("/*");
                    3: add_text("*/");
                    4: add_item(ACT_BYTE, CH_QUOTE);
                    5: add_item(ACT_BYTE, CH_SP);
                    6: add_item(ACT_BYTE, CH_STAR);
                    7: add_item(ACT_BYTE, CH_SLASH);
                    8: add_item(ACT_BYTE, $urandom_range(0, 1) ? 8'h09 : 8'h0D);
                    9: add_item(ACT_BYTE, 8'($urandom_range(0, 255)));
                    default: add_item(ACT_BYTE, 8'("a" + $urandom_range(0, 25)));
                endcase
            end
            if ($urandom_range(0, 19) == 0)
                add_item(ACT_EOF, 8'($urandom_range(0, 255)));
            else
                add_item(ACT_BYTE, CH_NL);
            if ($urandom_range(0, 60) == 0)
                drain_next = 1'b1;
            n_random = text_queue.size() - 25;
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        while (text_queue.size() > 0 || in_valid)
            @(posedge clk);
        while (line_results.size() > 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("%0d transactions in, %0d results checked, %0d lines closed",
                 n_in, n_out, n_closed);
        $display("final code line count %0d, %0d counts held at the saturation limit",
                 code_total, n_sat);
        if (n_fail == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // watchdog
    initial
    begin
        #4000000;
        $display("Mismatches found");
        $finish;
    end

endmodule

[filelist.f]
sv/ccl_pkg.sv
sv/ccl_step.sv
sv/code_line_counter.sv
bench/tb.sv
